@@ src/str_pkg.sv @@
// Package for the stepper trapezoid ramp: widths, codes and shared types.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package str_pkg;
  localparam int FRAC_BITS  = 8;
  localparam int DELAY_BITS = 24;
  localparam int FIX_W      = DELAY_BITS + FRAC_BITS;

  localparam logic [2:0] MODE_REL   = 3'd0;
  localparam logic [2:0] MODE_ABS   = 3'd1;
  localparam logic [2:0] MODE_STEP  = 3'd2;
  localparam logic [2:0] MODE_STOP  = 3'd3;
  localparam logic [2:0] MODE_ZERO  = 3'd4;
  localparam logic [2:0] MODE_LATCH = 3'd5;

  localparam logic [1:0] PH_STOP   = 2'd0;
  localparam logic [1:0] PH_ACCEL  = 2'd1;
  localparam logic [1:0] PH_CRUISE = 2'd2;
  localparam logic [1:0] PH_DECEL  = 2'd3;

  localparam logic [2:0] REG_MAX_SPEED = 3'd0;
  localparam logic [2:0] REG_ACCEL     = 3'd1;
  localparam logic [2:0] REG_DECEL     = 3'd2;
  localparam logic [2:0] REG_MIN_DELAY = 3'd3;
  localparam logic [2:0] REG_FIRST_DLY = 3'd4;

  // Datapath operation codes.
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_ENTRY = 3'd1; // decode command, stage move
  localparam logic [2:0] OP_START = 3'd2; // start ramp, compute nts dividend
  localparam logic [2:0] OP_PLAN  = 3'd3; // finish decel plan
  localparam logic [2:0] OP_RAMP  = 3'd4; // apply ramp delay update
  localparam logic [2:0] OP_FIN   = 3'd5; // count step, move position

  // Divider request selects.
  localparam logic [1:0] DIV_NTS  = 2'd0;
  localparam logic [1:0] DIV_DS   = 2'd1;
  localparam logic [1:0] DIV_Q    = 2'd2;
  localparam logic [1:0] DIV_RAMP = 2'd3;

  typedef struct packed {
    logic [2:0] op;
    logic       div_go;
    logic [1:0] div_sel;
  } cmd_t;

  typedef struct packed {
    logic       is_move;   // accepted move, step to be issued
    logic       is_step;   // step event while moving
    logic [1:0] phase;
    logic       div_busy;
    logic       decel_nz;
    logic       accel_nz;
  } sts_t;

  typedef struct packed {
    logic                  step_pulse;
    logic                  direction;
    logic [DELAY_BITS-1:0] next_delay_us;
    logic signed [31:0]    position;
    logic [1:0]            ramp_phase;
    logic                  move_done;
  } res_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] target_amount;
  } req_t;
endpackage

@@ src/str_if.sv @@
// Valid/ready channel interface carrying one payload word.
// The payload type is a parameter; the interface itself does not use str_pkg.
`timescale 1ns / 1ps
interface str_if #(type word_t = logic);
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/str_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle, 64-bit operands.
// Shared by the decel planner and the ramp delay recurrence.
`timescale 1ns / 1ps
module str_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        busy,
  output logic [63:0] quotient
);
  logic [63:0] q_r, q_nxt, rem_r, rem_nxt, d_r, d_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [64:0] trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    trial = {rem_r, q_r[63]};
    if (start) begin
      q_nxt = dividend; rem_nxt = '0; d_nxt = divisor; cnt_nxt = 7'd64; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = 64'(trial - {1'b0, d_r});
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial[63:0];
        q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt;
  end

  assign busy = busy_r;
  assign quotient = q_r;
endmodule

@@ src/str_datapath.sv @@
// Ramp datapath: configuration, position, ramp state and the shared divider.
// Depends on str_pkg and str_div; driven by str_ctrl through cmd_t.
`timescale 1ns / 1ps
module str_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [23:0]            cfg_data,
  input  str_pkg::req_t          req,
  input  str_pkg::cmd_t          cmd,
  output str_pkg::sts_t          sts,
  output str_pkg::res_t          res
);
  import str_pkg::*;

  logic [15:0] max_speed_r, accel_r, decel_r;
  logic [23:0] min_delay_r, first_delay_r;
  logic [1:0]  phase_r;
  logic [31:0] taken_r, total_r, dstart_r, pos_r, limit_r;
  logic [FIX_W-1:0] delay_r;
  logic        dir_r, done_r, pulse_r;
  logic        is_move_r, is_step_r;
  logic [63:0] nts_r, ds_r;
  logic [63:0] div_a, div_b, quo;
  logic        div_busy;

  logic [DELAY_BITS-1:0] mi, fi;
  logic signed [33:0] delta, t34, lim34;
  logic [32:0] mag;
  logic [FIX_W:0] acc_sum;
  logic [FIX_W-1:0] acc_new;
  logic [31:0] taken_inc;
  logic [63:0] qv;
  logic [31:0] spd_sq;
  logic [47:0] tot_dec, nts_acc;

  assign mi = (DELAY_BITS >= 24) ? DELAY_BITS'(min_delay_r)
            : ((min_delay_r >> DELAY_BITS) != 0 ? '1 : DELAY_BITS'(min_delay_r));
  assign fi = (DELAY_BITS >= 24) ? DELAY_BITS'(first_delay_r)
            : ((first_delay_r >> DELAY_BITS) != 0 ? '1 : DELAY_BITS'(first_delay_r));

  // The nts quotient never exceeds 32 bits, so the planner products stay narrow.
  assign spd_sq  = max_speed_r * max_speed_r;
  assign tot_dec = total_r * decel_r;
  assign nts_acc = nts_r[31:0] * accel_r;

  str_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_go), .dividend(div_a),
    .divisor(div_b), .busy(div_busy), .quotient(quo)
  );

  always_comb begin
    div_a = '0; div_b = 64'd1;
    case (cmd.div_sel)
      DIV_NTS: begin
        div_a = 64'(spd_sq);
        div_b = {47'd0, accel_r, 1'b0};
      end
      DIV_DS: begin
        div_a = 64'(tot_dec);
        div_b = 64'({1'b0, decel_r} + {1'b0, accel_r});
      end
      DIV_Q: begin
        div_a = 64'(nts_acc) + 64'(decel_r) - 64'd1;
        div_b = {48'd0, decel_r};
      end
      default: begin
        div_a = {31'd0, delay_r, 1'b0};
        if (phase_r == PH_DECEL)
          div_b = {30'd0, 32'(total_r - taken_r), 2'b00} + 64'd1;
        else
          div_b = {30'd0, taken_r, 2'b00} + 64'd1;
      end
    endcase
  end

  always_comb begin
    t34 = 34'(req.target_amount);
    lim34 = 34'(signed'(limit_r));
    if (limit_r != 0 && t34 > lim34) t34 = lim34;
    if (req.mode == MODE_REL) delta = 34'(req.target_amount);
    else delta = t34 - 34'(signed'(pos_r));
    mag = delta[33] ? 33'(-delta) : 33'(delta);
  end

  assign acc_sum = {1'b0, delay_r} + {1'b0, quo[FIX_W-1:0]};
  assign acc_new = (quo[63:FIX_W] != 0 || acc_sum[FIX_W]) ? '1 : acc_sum[FIX_W-1:0];
  assign taken_inc = taken_r + 32'd1;
  assign qv = quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r <= 16'd400; accel_r <= '0; decel_r <= '0;
      min_delay_r <= 24'd2500; first_delay_r <= '0;
      phase_r <= PH_STOP; taken_r <= '0; total_r <= '0; dstart_r <= '0;
      delay_r <= '0; pos_r <= '0; limit_r <= '0; dir_r <= 1'b0;
      done_r <= 1'b0; pulse_r <= 1'b0; is_move_r <= 1'b0; is_step_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_SPEED: max_speed_r <= cfg_data[15:0];
          REG_ACCEL:     accel_r <= cfg_data[15:0];
          REG_DECEL:     decel_r <= cfg_data[15:0];
          REG_MIN_DELAY: min_delay_r <= cfg_data;
          REG_FIRST_DLY: first_delay_r <= cfg_data;
          default: ;
        endcase
      end
      case (cmd.op)
        OP_ENTRY: begin
          pulse_r <= 1'b0; done_r <= 1'b0; is_move_r <= 1'b0; is_step_r <= 1'b0;
          case (req.mode)
            MODE_REL, MODE_ABS: begin
              if (phase_r == PH_STOP && delta != 0 && max_speed_r != 0) begin
                dir_r <= ~delta[33];
                total_r <= mag[31:0];
                is_move_r <= 1'b1;
                pulse_r <= 1'b1;
              end
            end
            MODE_STEP: begin
              if (phase_r != PH_STOP) begin
                is_step_r <= 1'b1;
                pulse_r <= 1'b1;
              end
            end
            MODE_STOP: begin
              phase_r <= PH_STOP; total_r <= '0; taken_r <= '0;
            end
            MODE_ZERO:  pos_r <= '0;
            MODE_LATCH: limit_r <= pos_r;
            default: ;
          endcase
        end
        OP_START: begin
          taken_r <= '0;
          if (fi <= mi || accel_r == 0) begin
            delay_r <= {mi, FRAC_BITS'(0)};
            phase_r <= PH_CRUISE;
          end else begin
            delay_r <= {fi, FRAC_BITS'(0)};
            phase_r <= PH_ACCEL;
          end
          dstart_r <= '0;
        end
        OP_PLAN: begin
          // Divider holds the q quotient when the ds estimate overshot nts.
          if (ds_r > nts_r)
            dstart_r <= (64'(total_r) > qv) ? 32'(64'(total_r) - qv) : 32'd0;
          else
            dstart_r <= ds_r[31:0];
        end
        OP_RAMP: begin
          case (phase_r)
            PH_ACCEL: begin
              logic [FIX_W-1:0] dn;
              dn = (qv > 64'(delay_r)) ? '0 : FIX_W'(64'(delay_r) - qv);
              if (dn[FIX_W-1:FRAC_BITS] <= mi) begin
                delay_r <= {mi, FRAC_BITS'(0)};
                phase_r <= PH_CRUISE;
              end else begin
                delay_r <= dn;
              end
              if (decel_r != 0 && taken_r >= dstart_r) phase_r <= PH_DECEL;
            end
            PH_CRUISE: begin
              if (decel_r != 0 && taken_r >= dstart_r) phase_r <= PH_DECEL;
            end
            PH_DECEL: delay_r <= acc_new;
            default: ;
          endcase
        end
        OP_FIN: begin
          taken_r <= taken_inc;
          pos_r <= dir_r ? pos_r + 32'd1 : pos_r - 32'd1;
          if (taken_inc >= total_r) begin
            phase_r <= PH_STOP; total_r <= '0; done_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Divider results captured by the controller's sequencing: nts then ds.
  always_ff @(posedge clk) begin
    if (cmd.div_go && cmd.div_sel == DIV_DS) nts_r <= (accel_r != 0) ? quo : 64'd0;
    if (cmd.div_go && cmd.div_sel == DIV_Q) ds_r <= quo;
    if (cmd.op == OP_START) begin
      nts_r <= '0; ds_r <= '0;
    end
  end

  assign sts.is_move  = is_move_r;
  assign sts.is_step  = is_step_r;
  assign sts.phase    = phase_r;
  assign sts.div_busy = div_busy;
  assign sts.decel_nz = (decel_r != 0);
  assign sts.accel_nz = (accel_r != 0);

  assign res.step_pulse    = pulse_r;
  assign res.direction     = dir_r;
  assign res.next_delay_us = (phase_r != PH_STOP) ? delay_r[FIX_W-1:FRAC_BITS] : '0;
  assign res.position      = signed'(pos_r);
  assign res.ramp_phase    = phase_r;
  assign res.move_done     = done_r;
endmodule

@@ src/str_ctrl.sv @@
// Controller state machine: sequences entry, decel planning, ramp and finish.
// Depends on str_pkg; drives str_datapath through cmd_t and reads sts_t.
`timescale 1ns / 1ps
module str_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic          out_busy,
  output logic          in_rdy,
  output logic          res_load,
  input  str_pkg::sts_t sts,
  output str_pkg::cmd_t cmd
);
  import str_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_NTS   = 4'd2;
  localparam logic [3:0] S_DS    = 4'd3;
  localparam logic [3:0] S_Q     = 4'd4;
  localparam logic [3:0] S_PLAN  = 4'd5;
  localparam logic [3:0] S_RDIV  = 4'd6;
  localparam logic [3:0] S_RAMP  = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] st_r, st_nxt;

  always_comb begin
    st_nxt = st_r;
    cmd = '{op: OP_NONE, div_go: 1'b0, div_sel: DIV_NTS};
    res_load = 1'b0;
    in_rdy = 1'b0;
    case (st_r)
      S_IDLE: begin
        in_rdy = 1'b1;
        if (in_fire) begin
          cmd.op = OP_ENTRY;
          st_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.is_move) begin
          cmd.op = OP_START;
          cmd.div_go = 1'b1; cmd.div_sel = DIV_NTS;
          st_nxt = sts.decel_nz ? S_NTS : S_FIN;
        end else if (sts.is_step) begin
          cmd.div_go = 1'b1; cmd.div_sel = DIV_RAMP;
          st_nxt = S_RDIV;
        end else begin
          st_nxt = S_OUT;
        end
      end
      S_NTS: if (!sts.div_busy) begin
        cmd.div_go = 1'b1; cmd.div_sel = DIV_DS; st_nxt = S_DS;
      end
      S_DS: if (!sts.div_busy) begin
        cmd.div_go = 1'b1; cmd.div_sel = DIV_Q; st_nxt = S_Q;
      end
      S_Q: if (!sts.div_busy) st_nxt = S_PLAN;
      S_PLAN: begin
        cmd.op = OP_PLAN; st_nxt = S_FIN;
      end
      S_RDIV: if (!sts.div_busy) st_nxt = S_RAMP;
      S_RAMP: begin
        cmd.op = OP_RAMP; cmd.div_sel = DIV_RAMP; st_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.op = OP_FIN; st_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_busy) begin
          res_load = 1'b1; st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) in_fire |-> st_r == S_IDLE)
    else $error("word accepted while busy");
  assert property (@(posedge clk) disable iff (!rst_n) res_load |-> !out_busy)
    else $error("result loaded over a pending word");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RAMP || st_r == S_PLAN) |-> !sts.div_busy)
    else $error("divider result used while busy");
endmodule

@@ src/stepper_trapezoid_ramp.sv @@
// Top level of the trapezoidal stepper ramp generator.
// Depends on str_pkg, str_if, str_ctrl and str_datapath.
//
// Usage: every word on the input channel (mode, target_amount) yields exactly
// one word on the result channel. Commands (stop, zero, latch limit, ignored
// moves) go from decode straight to the output state. A step event waits on
// the shared divider that evaluates the delay recurrence. A move start
// with decel zero goes from decode to finish; with decel nonzero it runs the
// decel planner, three divisions on the same divider. One word
// is in flight at a time; the next is accepted once the result has been
// placed in the output register.
// The output register holds its word until the receiver takes it; while it
// is full the block finishes the current word and waits before loading.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect at once and
// are meant to be issued while idle. Synchronous reset clears the ramp
// state, position and limit and loads register defaults (speed 400, min
// delay 2500 us).
`timescale 1ns / 1ps
module stepper_trapezoid_ramp (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  str_if.sink         in_ch,
  str_if.source       out_ch
);
  import str_pkg::*;

  sts_t  sts;
  cmd_t  cmd;
  res_t  res;
  req_t  req_r;
  res_t  out_r;
  logic  out_v_r, in_rdy, res_load, in_fire;

  assign in_fire = in_ch.valid & in_rdy;
  assign in_ch.ready = in_rdy;

  always_ff @(posedge clk) begin
    if (in_fire) req_r <= in_ch.data;
  end

  str_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_busy(out_v_r),
    .in_rdy(in_rdy), .res_load(res_load), .sts(sts), .cmd(cmd)
  );

  str_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(in_fire ? req_t'(in_ch.data) : req_r),
    .cmd(cmd), .sts(sts), .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (res_load) out_v_r <= 1'b1;
    else if (out_ch.ready) out_v_r <= 1'b0;
    if (res_load) out_r <= res;
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;
endmodule

@@ verif/str_ramp_checker.sv @@
// Checker for the stepper trapezoid ramp: mirrors the configuration writes,
// predicts one result word per accepted input word and compares. Uses str_pkg.
`timescale 1ns / 1ps
module str_ramp_checker
  import str_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  req_t        in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  res_t        out_data,
  output int          pending,
  output int          errors
);
  localparam longint unsigned DELAY_SAT = (64'd1 << FIX_W) - 1;

  // Mirrored registers.
  logic [15:0] speed_cfg, accel_cfg, decel_cfg;
  logic [23:0] min_dly_cfg, first_dly_cfg;

  // Ramp state of the predictor.
  logic [1:0]       phase_q;
  logic [31:0]      taken_q, total_q, dec_start_q, pos_q, limit_q;
  logic             dir_q;
  longint unsigned  delay_q;

  res_t ramp_words_due[$];

  initial begin
    pending = 0;
    errors  = 0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("Mismatch in %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  function automatic void plan_decel_start();
    longint unsigned spd, acc, dec, tot, nts, ds, q;
    spd = speed_cfg;
    acc = accel_cfg;
    dec = decel_cfg;
    tot = total_q;
    if (dec == 0) begin
      dec_start_q = '0;
    end else begin
      nts = (acc != 0) ? (spd * spd) / (2 * acc) : 0;
      ds  = (tot * dec) / (dec + acc);
      if (ds > nts) begin
        q  = (nts * acc + dec - 1) / dec;
        ds = (tot > q) ? tot - q : 0;
      end
      dec_start_q = ds[31:0];
    end
  endfunction

  // Issues one step and advances the ramp; returns 1 when the move ends.
  function automatic logic take_step();
    longint unsigned n, inc, mi, fi, remain;
    logic [31:0] left;
    mi = min_dly_cfg;
    fi = first_dly_cfg;
    n  = taken_q;
    case (phase_q)
      PH_STOP: begin
        taken_q = '0;
        n = 0;
        if (fi <= mi || accel_cfg == 0) begin
          delay_q = mi << FRAC_BITS;
          phase_q = PH_CRUISE;
        end else begin
          delay_q = fi << FRAC_BITS;
          phase_q = PH_ACCEL;
        end
        plan_decel_start();
      end
      PH_ACCEL: begin
        inc = (2 * delay_q) / (4 * n + 1);
        delay_q = (inc > delay_q) ? 0 : delay_q - inc;
        if ((delay_q >> FRAC_BITS) <= mi) begin
          delay_q = mi << FRAC_BITS;
          phase_q = PH_CRUISE;
        end
        if (decel_cfg != 0 && n >= dec_start_q) phase_q = PH_DECEL;
      end
      PH_CRUISE: begin
        if (decel_cfg != 0 && n >= dec_start_q) phase_q = PH_DECEL;
      end
      default: begin
        left = total_q - taken_q;
        remain = left;
        inc = (2 * delay_q) / (4 * remain + 1);
        delay_q = delay_q + inc;
        if (delay_q > DELAY_SAT) delay_q = DELAY_SAT;
      end
    endcase
    taken_q = taken_q + 1;
    pos_q = dir_q ? pos_q + 1 : pos_q - 1;
    if (taken_q >= total_q) begin
      phase_q = PH_STOP;
      total_q = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic res_t predict_ramp_word(input logic [2:0] mode, input logic [31:0] amount);
    res_t   r;
    longint delta, tgt;
    logic   stepped, done;
    stepped = 1'b0;
    done    = 1'b0;
    case (mode)
      MODE_REL, MODE_ABS: begin
        if (mode == MODE_REL) begin
          delta = $signed(amount);
        end else begin
          tgt = $signed(amount);
          if (limit_q != 0 && tgt > longint'($signed(limit_q))) tgt = $signed(limit_q);
          delta = tgt - longint'($signed(pos_q));
        end
        if (phase_q == PH_STOP && delta != 0 && speed_cfg != 0) begin
          dir_q = (delta > 0);
          if (delta < 0) delta = -delta;
          total_q = delta[31:0];
          done = take_step();
          stepped = 1'b1;
        end
      end
      MODE_STEP: begin
        if (phase_q != PH_STOP) begin
          done = take_step();
          stepped = 1'b1;
        end
      end
      MODE_STOP: begin
        phase_q = PH_STOP;
        total_q = '0;
        taken_q = '0;
      end
      MODE_ZERO:  pos_q = '0;
      MODE_LATCH: limit_q = pos_q;
      default: ;
    endcase
    r.step_pulse    = stepped;
    r.direction     = dir_q;
    r.next_delay_us = (phase_q != PH_STOP) ? delay_q[FIX_W-1:FRAC_BITS] : '0;
    r.position      = pos_q;
    r.ramp_phase    = phase_q;
    r.move_done     = done;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      speed_cfg     = 16'd400;
      accel_cfg     = '0;
      decel_cfg     = '0;
      min_dly_cfg   = 24'd2500;
      first_dly_cfg = '0;
      phase_q       = PH_STOP;
      taken_q       = '0;
      total_q       = '0;
      dec_start_q   = '0;
      delay_q       = 0;
      pos_q         = '0;
      limit_q       = '0;
      dir_q         = 1'b0;
      ramp_words_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_SPEED: speed_cfg     = cfg_data[15:0];
          REG_ACCEL:     accel_cfg     = cfg_data[15:0];
          REG_DECEL:     decel_cfg     = cfg_data[15:0];
          REG_MIN_DELAY: min_dly_cfg   = cfg_data;
          REG_FIRST_DLY: first_dly_cfg = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (ramp_words_due.size() == 0) begin
          report_mismatch("unexpected word, position", out_data.position, 0);
        end else begin
          want = ramp_words_due.pop_front();
          if (out_data.step_pulse !== want.step_pulse)
            report_mismatch("step_pulse", out_data.step_pulse, want.step_pulse);
          if (out_data.direction !== want.direction)
            report_mismatch("direction", out_data.direction, want.direction);
          if (out_data.next_delay_us !== want.next_delay_us)
            report_mismatch("next_delay_us", out_data.next_delay_us, want.next_delay_us);
          if (out_data.position !== want.position)
            report_mismatch("position", out_data.position, want.position);
          if (out_data.ramp_phase !== want.ramp_phase)
            report_mismatch("ramp_phase", out_data.ramp_phase, want.ramp_phase);
          if (out_data.move_done !== want.move_done)
            report_mismatch("move_done", out_data.move_done, want.move_done);
        end
      end
      if (in_valid && in_ready)
        ramp_words_due.push_back(predict_ramp_word(in_data.mode, in_data.target_amount));
    end
    pending = ramp_words_due.size();
  end
endmodule

@@ verif/tb_top.sv @@
// Testbench top for the stepper trapezoid ramp: clock, reset, configuration
// profiles and command stimulus. Depends on str_pkg, str_if and str_ramp_checker.
`timescale 1ns / 1ps
module tb_top;
  import str_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_MAX_SPEED;
  logic [23:0] cfg_data = '0;
  logic        calm = 1'b0;
  int          stall_left = 0;
  int          cycles = 0;
  int          pending, errors;

  str_if #(.word_t(req_t)) in_ch ();
  str_if #(.word_t(res_t)) out_ch ();

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  stepper_trapezoid_ramp i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  str_ramp_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_data   (in_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data),
    .pending   (pending),
    .errors    (errors)
  );

  // Result side stalls in bursts of random length.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (calm) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_cmd(input logic [2:0] mode, input logic [31:0] amount);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data.mode <= mode;
    in_ch.data.target_amount <= amount;
    @(posedge clk iff in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic load_profile(input logic [15:0] spd, input logic [15:0] acc,
                              input logic [15:0] dec, input logic [23:0] min_dly,
                              input logic [23:0] first_dly);
    drain();
    write_reg(REG_MAX_SPEED, 24'(spd));
    write_reg(REG_ACCEL, 24'(acc));
    write_reg(REG_DECEL, 24'(dec));
    write_reg(REG_MIN_DELAY, min_dly);
    write_reg(REG_FIRST_DLY, first_dly);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed moves followed by their step events, some cut short,
  // mixed with stop, zero, latch and fully random words.
  task automatic run_moves(input int count);
    int sent, pick, steps, mag;
    logic [2:0]  mode;
    logic [31:0] amount;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 11);
      if (pick < 7) begin
        mag = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 120) : $urandom_range(1, 30);
        if (pick < 5) begin
          amount = $urandom_range(0, 1) ? mag : -mag;
          send_cmd(MODE_REL, amount);
        end else begin
          amount = $urandom_range(0, 1) ? mag : -mag;
          send_cmd(MODE_ABS, amount);
          mag = mag * 2 + 2;
        end
        steps = ($urandom_range(0, 7) == 0) ? $urandom_range(0, mag) : mag + $urandom_range(0, 2);
        repeat (steps) send_cmd(MODE_STEP, $urandom);
        sent += steps + 1;
      end else begin
        case (pick)
          7:  send_cmd(MODE_STOP, $urandom);
          8:  send_cmd(MODE_ZERO, $urandom);
          9:  send_cmd(MODE_LATCH, $urandom);
          default: begin
            mode = 3'($urandom_range(0, 7));
            amount = $urandom;
            send_cmd(mode, amount);
            if (mode <= MODE_ABS) send_cmd(MODE_STOP, 0);
          end
        endcase
        sent++;
      end
    end
  endtask

  initial begin
    int wait_cycles;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words under the reset profile: cruise-only moves.
    send_cmd(MODE_REL, 32'd3);
    send_cmd(MODE_STEP, 32'd0);
    send_cmd(MODE_STEP, 32'd0);
    send_cmd(MODE_REL, -32'sd2);
    send_cmd(MODE_REL, 32'd5);          // ignored, a move is running
    send_cmd(MODE_STEP, 32'd0);
    send_cmd(MODE_STEP, 32'd0);         // step event while stopped
    send_cmd(MODE_REL, 32'd0);          // zero count
    send_cmd(MODE_REL, 32'd4);
    send_cmd(MODE_ZERO, 32'd0);         // zero position during a move
    send_cmd(MODE_STOP, 32'd0);
    send_cmd(MODE_REL, 32'd2);
    send_cmd(MODE_STEP, 32'd0);
    send_cmd(MODE_LATCH, 32'd0);
    send_cmd(MODE_ABS, 32'd1000);       // clamped to the limit, no distance
    send_cmd(MODE_ABS, -32'sd3);
    send_cmd(MODE_STOP, 32'd0);
    send_cmd(MODE_ZERO, 32'd0);
    send_cmd(MODE_LATCH, 32'd0);        // limit back to zero, no clamping
    send_cmd(MODE_ABS, 32'h7FFF_FFFF);
    send_cmd(MODE_STEP, 32'hFFFF_FFFF);
    send_cmd(MODE_STOP, 32'd0);
    send_cmd(MODE_ABS, 32'h8000_0000);
    send_cmd(MODE_STOP, 32'd0);
    send_cmd(3'd6, 32'hFFFF_FFFF);
    send_cmd(3'd7, 32'd0);

    run_moves(60);
    load_profile(16'd1000, 16'd2000, 16'd3000, 24'd1000, 24'd21377);
    run_moves(130);
    load_profile(16'hFFFF, 16'hFFFF, 16'd1, 24'd0, 24'hFF_FFFF);
    run_moves(90);
    load_profile(16'd0, 16'd0, 16'hFFFF, 24'hFF_FFFF, 24'd0);
    run_moves(30);
    load_profile(16'd300, 16'd100, 16'd0, 24'd3333, 24'd100000);
    run_moves(110);
    load_profile(16'hFFFF, 16'd1, 16'hFFFF, 24'd1, 24'd5000);
    run_moves(100);
    calm <= 1'b1;
    run_moves(80);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
